@@ hw/rtl/bounded_deque_unit_assert.svh @@
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DEQUE_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BDQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

@@ hw/rtl/bdq_pkg.sv @@
// Shared constants, codes and control types of the bounded deque.
package bdq_pkg;

   localparam int DefaultDepth = 16;
   localparam int DataWidth    = 32;
   localparam int OpWidth      = 2;
   localparam int StatusWidth  = 2;

   localparam logic [OpWidth-1:0] OP_PUSH_BACK  = 2'd0;
   localparam logic [OpWidth-1:0] OP_PUSH_FRONT = 2'd1;
   localparam logic [OpWidth-1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [OpWidth-1:0] OP_POP_BACK   = 2'd3;

   localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
   localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

   // Word returned by a pop on an empty queue.
   localparam logic signed [DataWidth-1:0] EmptyPopValue = -32'sd1;

   typedef struct packed {
      logic capture;   // latch the incoming command word
      logic execute;   // access the ring and update the pointers
   } ctrl_cmd_type;

endpackage

@@ hw/rtl/bdq_controller.sv @@
// Sequencer of the bounded deque: accept, execute, respond.
module bdq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output bdq_pkg::ctrl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy        = (state_ff == S_EXEC);
   assign accept      = start & ~busy;
   assign rsp_valid   = (state_ff == S_RESP);
   assign cmd.capture = accept;
   assign cmd.execute = busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_RESP;
         S_RESP:  state_in = accept ? S_EXEC : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/bdq_datapath.sv @@
// Ring memory, front pointer and item count of the bounded deque.
module bdq_datapath #(
   parameter int DEPTH = bdq_pkg::DefaultDepth
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  bdq_pkg::ctrl_cmd_type                    cmd,
   input  logic        [bdq_pkg::OpWidth-1:0]       req_opcode,
   input  logic signed [bdq_pkg::DataWidth-1:0]     req_push_value,
   output logic signed [bdq_pkg::DataWidth-1:0]     rsp_pop_value,
   output logic        [bdq_pkg::StatusWidth-1:0]   rsp_status,
   output logic        [$clog2(DEPTH+1)-1:0]        rsp_item_count
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int SumW = CntW + 1;
   localparam logic [IdxW-1:0] LastSlot = IdxW'(DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
   localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

   logic [bdq_pkg::DataWidth-1:0] ring_ff [DEPTH];
   logic [bdq_pkg::DataWidth-1:0] rd_ff;

   logic [bdq_pkg::OpWidth-1:0]   op_ff;
   logic [bdq_pkg::DataWidth-1:0] value_ff;
   logic [IdxW-1:0]               front_ff, front_in;
   logic [CntW-1:0]               count_ff, count_in;
   logic [bdq_pkg::StatusWidth-1:0] status_ff, status_in;
   logic                          is_pop_ff;

   logic            is_push, full, empty;
   logic [SumW-1:0] sum_raw;
   logic [IdxW-1:0] tail_slot, last_slot, front_dec, front_inc, addr;
   logic            wr_en;

   assign is_push = ~op_ff[1];
   assign full    = (count_ff == DepthCnt);
   assign empty   = (count_ff == '0);

   // Slot after the back item; the sum stays below twice the depth.
   assign sum_raw   = SumW'(front_ff) + SumW'(count_ff);
   assign tail_slot = (sum_raw >= DepthSum) ? IdxW'(sum_raw - DepthSum) : IdxW'(sum_raw);
   assign last_slot = (tail_slot == '0) ? LastSlot : tail_slot - 1'b1;
   assign front_dec = (front_ff == '0) ? LastSlot : front_ff - 1'b1;
   assign front_inc = (front_ff == LastSlot) ? '0 : front_ff + 1'b1;

   always_comb begin
      addr      = front_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = bdq_pkg::ST_OK;
      unique case (op_ff)
         bdq_pkg::OP_PUSH_BACK: begin
            addr = tail_slot;
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         bdq_pkg::OP_PUSH_FRONT: begin
            addr = front_dec;
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               front_in = front_dec;
               count_in = count_ff + 1'b1;
            end
         end
         bdq_pkg::OP_POP_FRONT: begin
            addr = front_ff;
            if (empty) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else begin
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         bdq_pkg::OP_POP_BACK: begin
            addr = last_slot;
            if (empty) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: addr = front_ff;
      endcase
   end

   assign wr_en = cmd.execute & is_push & ~full;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[addr] <= value_ff;
      end
      if (cmd.execute) begin
         rd_ff <= ring_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         value_ff <= req_push_value;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         is_pop_ff <= ~is_push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      if (!is_pop_ff) begin
         rsp_pop_value = '0;
      end else if (status_ff == bdq_pkg::ST_EMPTY) begin
         rsp_pop_value = bdq_pkg::EmptyPopValue;
      end else begin
         rsp_pop_value = rd_ff;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_item_count = count_ff;

endmodule

@@ hw/rtl/bounded_deque_unit.sv @@
// Top level of the bounded deque: a double-ended queue of signed words in a ring memory.
// The block holds up to DEPTH signed 32-bit words and takes one command word at a time:
// push at back, push at front, pop from front or pop from back. A command is taken at
// a rising edge where start is high and busy is low. In the execute cycle the ring
// memory is read or written at one slot (its read data is registered) and the front
// pointer and count are updated, and in the response cycle the result word is shown
// for exactly one cycle with rsp_valid high. busy is high only in the execute cycle,
// so a new command may be given in the response cycle, while the last result is
// shown. The receiver cannot hold results off; it must take each result word in the
// cycle it is shown. A pop returns the removed word, a pop on an empty queue
// returns -1 with the empty status, and a push on a full queue is dropped with the
// full status and returns 0, as every push does. Every result carries the number
// of words held after the command. Reset clears only the sequencer state, the
// pointer and the count; the memory needs no clearing pass because the read data
// of a slot is shown only after a push has written it.
module bounded_deque_unit #(
   parameter int DEPTH = bdq_pkg::DefaultDepth
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic        [bdq_pkg::OpWidth-1:0]     req_opcode,
   input  logic signed [bdq_pkg::DataWidth-1:0]   req_push_value,
   output logic                                   rsp_valid,
   output logic signed [bdq_pkg::DataWidth-1:0]   rsp_pop_value,
   output logic        [bdq_pkg::StatusWidth-1:0] rsp_status,
   output logic        [$clog2(DEPTH+1)-1:0]      rsp_item_count
);

   // Commands from the sequencer to the datapath.
   bdq_pkg::ctrl_cmd_type cmd;

   bdq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_item_count (rsp_item_count)
   );

endmodule

@@ hw/rtl/bdq_checker.sv @@
// Port-level checks of the bounded deque and their binding to the top level.
`include "bounded_deque_unit_assert.svh"

module bdq_checker #(
   parameter int DEPTH = bdq_pkg::DefaultDepth
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic signed [bdq_pkg::DataWidth-1:0]   rsp_pop_value,
   input logic        [bdq_pkg::StatusWidth-1:0] rsp_status,
   input logic        [$clog2(DEPTH+1)-1:0]      rsp_item_count
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

   // An accepted command occupies the block in the next cycle.
   `BDQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // Every execute cycle is followed by a result word, with busy low.
   `BDQ_ASSERT_NEXT(a_exec_result, clock, reset, busy, rsp_valid && !busy)
   // An empty pop always returns minus one and reports a count of zero.
   `BDQ_ASSERT_NOW(a_empty_value, clock, reset,
      rsp_valid && rsp_status == bdq_pkg::ST_EMPTY,
      rsp_pop_value == bdq_pkg::EmptyPopValue && rsp_item_count == '0)
   // A dropped push happens only at the capacity limit.
   `BDQ_ASSERT_NOW(a_full_count, clock, reset,
      rsp_valid && rsp_status == bdq_pkg::ST_FULL, rsp_item_count == DepthCnt)
   // The count never exceeds the capacity.
   `BDQ_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_item_count <= DepthCnt)

endmodule

bind bounded_deque_unit bdq_checker #(
   .DEPTH (DEPTH)
) u_bdq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_pop_value  (rsp_pop_value),
   .rsp_status     (rsp_status),
   .rsp_item_count (rsp_item_count)
);
